### rtl/core/keystream_subset_sampler_macros.svh
// Assertion macros shared by the keystream subset sampler RTL.
`ifndef KEYSTREAM_SUBSET_SAMPLER_MACROS_SVH
`define KEYSTREAM_SUBSET_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define KSS_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("kss: invariant violated");
// Check that an antecedent implies a consequent in the same cycle.
`define KSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kss: implication violated");
`else
`define KSS_ASSERT(label, clk, rst_n, cond)
`define KSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/kss_pkg.sv
// Shared types, constants and helper functions of the keystream subset sampler.
package kss_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int SLACK_WORDS = 1000;
    localparam int IDX_W       = 10;
    localparam int SLOT_W      = 11;
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 17;
    localparam int FQ_DEPTH    = 4;
    localparam int FQ_AW       = 2;
    localparam int RQ_DEPTH    = 2;

    // Register index, taken from paddr[2]
    localparam logic REG_VALID_LIMIT = 1'b0;
    localparam logic REG_SLOT_TOTAL  = 1'b1;

    localparam logic [VAL_W-1:0]  RST_VALID_LIMIT = 16'd1024;
    localparam logic [SLOT_W-1:0] RST_SLOT_TOTAL  = 11'd64;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_WORD  = 2'd2
    } t_kind;

    // Classified beat handed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  data;
        logic              hit;
    } t_op;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [VAL_W-1:0] chosen;
        logic             complete;
        logic             exhausted;
    } t_res;

    // Live configuration with derived values
    typedef struct packed {
        logic [VAL_W-1:0]  valid_limit;
        logic [VAL_W-1:0]  mask;
        logic [SLOT_W-1:0] slot_cnt;
        logic [CNT_W-1:0]  budget;
    } t_cfg;

    typedef struct packed {
        logic              running;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  match_cnt;
        logic [CNT_W-1:0]  words;
    } t_back_stat;

    // All ones up to and including the top set bit
    function automatic logic [VAL_W-1:0] f_mask(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] f_budget(input logic [VAL_W-1:0] v);
        return {1'b0, f_mask(v)} + CNT_W'(1) + CNT_W'(SLACK_WORDS);
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot_cnt(input logic [SLOT_W-1:0] s);
        return (s > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : s;
    endfunction

endpackage

### rtl/core/keystream_subset_sampler.sv
// A keystream word is registered in the front queue and its result in the result queue, from
// which it reaches the output ports when neither queue holds anything older.
// Throughput: one beat per cycle while the front queue is not full; the back end takes one
// queued beat per cycle while the two-entry result queue has room.
// Reset: counters, run flag and queues clear; valid_limit goes to 1024, slot total to 64.
// The threshold table is not cleared and holds no value until loaded.
`include "keystream_subset_sampler_macros.svh"

module keystream_subset_sampler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_kind,
    input  logic [kss_pkg::IDX_W-1:0]  i_table_index,
    input  logic [kss_pkg::VAL_W-1:0]  i_table_value,
    input  logic [kss_pkg::VAL_W-1:0]  i_random_word,
    output logic                       empty,
    input  logic                       pop,
    output logic [kss_pkg::IDX_W-1:0]  o_slot,
    output logic [kss_pkg::VAL_W-1:0]  o_chosen_index,
    output logic                       o_subset_complete,
    output logic                       o_budget_exhausted,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [kss_pkg::VAL_W-1:0]   r_valid_limit;
    logic [kss_pkg::SLOT_W-1:0]  r_slot_total;
    kss_pkg::t_cfg               r_cfg;
    kss_pkg::t_op                op;
    logic                        op_valid;
    logic                        op_take;
    kss_pkg::t_res               res;
    kss_pkg::t_back_stat         stat;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers and their derived values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_limit  <= kss_pkg::RST_VALID_LIMIT;
            r_slot_total   <= kss_pkg::RST_SLOT_TOTAL;
            r_cfg.valid_limit <= kss_pkg::RST_VALID_LIMIT;
            r_cfg.mask     <= kss_pkg::f_mask(kss_pkg::RST_VALID_LIMIT);
            r_cfg.budget   <= kss_pkg::f_budget(kss_pkg::RST_VALID_LIMIT);
            r_cfg.slot_cnt <= kss_pkg::f_slot_cnt(kss_pkg::RST_SLOT_TOTAL);
        end else if (cfg_wr) begin
            if (paddr[2] == kss_pkg::REG_VALID_LIMIT) begin
                r_valid_limit     <= pwdata[kss_pkg::VAL_W-1:0];
                r_cfg.valid_limit <= pwdata[kss_pkg::VAL_W-1:0];
                r_cfg.mask        <= kss_pkg::f_mask(pwdata[kss_pkg::VAL_W-1:0]);
                r_cfg.budget      <= kss_pkg::f_budget(pwdata[kss_pkg::VAL_W-1:0]);
            end else begin
                r_slot_total   <= pwdata[kss_pkg::SLOT_W-1:0];
                r_cfg.slot_cnt <= kss_pkg::f_slot_cnt(pwdata[kss_pkg::SLOT_W-1:0]);
            end
        end
    end

    // Return register contents on reads
    always_comb begin
        if (paddr[2] == kss_pkg::REG_SLOT_TOTAL) begin
            prdata = {21'd0, r_slot_total};
        end else begin
            prdata = {16'd0, r_valid_limit};
        end
    end

    kss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_kind        (i_kind),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_random_word (i_random_word),
        .i_cfg         (r_cfg),
        .o_full        (full),
        .o_op          (op),
        .o_op_valid    (op_valid),
        .i_op_take     (op_take)
    );

    kss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_take  (op_take),
        .i_pop      (pop),
        .o_res      (res),
        .o_empty    (empty),
        .o_stat     (stat)
    );

    assign o_slot             = res.slot;
    assign o_chosen_index     = res.chosen;
    assign o_subset_complete  = res.complete;
    assign o_budget_exhausted = res.exhausted;

    // A result never closes a run both ways at once
    `KSS_ASSERT(a_end_excl, i_clk, i_rst_n, empty || !(o_subset_complete && o_budget_exhausted))
    // Every counted match came from a counted word
    `KSS_ASSERT(a_match_le_words, i_clk, i_rst_n, stat.match_cnt <= stat.words)
    // Every filled slot came from a counted match
    `KSS_ASSERT(a_slot_le_match, i_clk, i_rst_n, {6'd0, stat.slot} <= stat.match_cnt)
    // A run only starts from cleared counters
    `KSS_ASSERT_IMPL(a_start_clr, i_clk, i_rst_n, $rose(stat.running), !(|stat.slot || |stat.words))

endmodule

### rtl/core/kss_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module kss_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [1:0]                 i_kind,
    input  logic [kss_pkg::IDX_W-1:0]  i_table_index,
    input  logic [kss_pkg::VAL_W-1:0]  i_table_value,
    input  logic [kss_pkg::VAL_W-1:0]  i_random_word,
    input  kss_pkg::t_cfg              i_cfg,
    output logic                       o_full,
    output kss_pkg::t_op               o_op,
    output logic                       o_op_valid,
    input  logic                       i_op_take
);

    kss_pkg::t_op                r_q [kss_pkg::FQ_DEPTH];
    logic [kss_pkg::FQ_AW-1:0]   r_wp;
    logic [kss_pkg::FQ_AW-1:0]   r_rp;
    logic [kss_pkg::FQ_AW:0]     r_cnt;
    logic [kss_pkg::VAL_W-1:0]   masked;
    logic                        known;
    logic                        enq;
    logic                        deq;
    kss_pkg::t_op                op_in;

    // Classify the incoming beat
    always_comb begin
        masked       = i_random_word & i_cfg.mask;
        known        = 1'b1;
        op_in.kind   = kss_pkg::KIND_WORD;
        op_in.idx    = i_table_index;
        op_in.data   = masked;
        op_in.hit    = masked < i_cfg.valid_limit;
        unique case (kss_pkg::t_kind'(i_kind))
            kss_pkg::KIND_LOAD: begin
                op_in.kind = kss_pkg::KIND_LOAD;
                op_in.data = i_table_value;
            end
            kss_pkg::KIND_START: begin
                op_in.kind = kss_pkg::KIND_START;
            end
            kss_pkg::KIND_WORD: begin
                op_in.kind = kss_pkg::KIND_WORD;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_full     = (r_cnt == (kss_pkg::FQ_AW+1)'(kss_pkg::FQ_DEPTH));
    assign enq        = i_push && !o_full && known;
    assign o_op_valid = (r_cnt != '0);
    assign deq        = i_op_take && o_op_valid;
    assign o_op       = r_q[r_rp];

    // Advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) r_wp <= r_wp + 1'b1;
            if (deq) r_rp <= r_rp + 1'b1;
            if (enq && !deq) r_cnt <= r_cnt + 1'b1;
            else if (deq && !enq) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Hold queued beats
    always_ff @(posedge i_clk) begin
        if (enq) r_q[r_wp] <= op_in;
    end

endmodule

### rtl/core/kss_back.sv
// Back end: threshold table, run counters, slot selection and result queue.
module kss_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kss_pkg::t_cfg        i_cfg,
    input  kss_pkg::t_op         i_op,
    input  logic                 i_op_valid,
    output logic                 o_op_take,
    input  logic                 i_pop,
    output kss_pkg::t_res        o_res,
    output logic                 o_empty,
    output kss_pkg::t_back_stat  o_stat
);

    logic [kss_pkg::VAL_W-1:0]  r_mem [kss_pkg::MAX_SLOTS];
    logic [kss_pkg::VAL_W-1:0]  r_rd;
    logic                       r_fwd;
    logic [kss_pkg::VAL_W-1:0]  r_fwd_data;
    logic [kss_pkg::VAL_W-1:0]  r_cur;
    logic [kss_pkg::VAL_W-1:0]  r_thr0;

    logic [kss_pkg::CNT_W-1:0]  r_match, n_match;
    logic [kss_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [kss_pkg::CNT_W-1:0]  r_words, n_words;
    logic                       r_running, n_running;

    kss_pkg::t_res              r_rq [kss_pkg::RQ_DEPTH];
    logic                       r_rq_wp;
    logic                       r_rq_rp;
    logic [1:0]                 r_rq_cnt;

    logic                       rq_pop;
    logic                       rq_push;
    logic                       space;
    logic                       emit;
    logic                       exh;
    logic                       complete;
    logic                       stop_pre;
    logic                       is_load;
    logic [kss_pkg::IDX_W-1:0]  rd_addr;
    logic [kss_pkg::VAL_W-1:0]  next_thr;
    kss_pkg::t_res              res_in;

    assign rq_pop    = i_pop && (r_rq_cnt != 2'd0);
    assign space     = (r_rq_cnt != 2'(kss_pkg::RQ_DEPTH)) || rq_pop;
    assign o_op_take = i_op_valid && space;
    assign is_load   = o_op_take && (i_op.kind == kss_pkg::KIND_LOAD);
    assign next_thr  = r_fwd ? r_fwd_data : r_rd;
    assign stop_pre  = (r_slot >= i_cfg.slot_cnt) || (r_match >= {1'b0, i_cfg.valid_limit})
                    || (r_words >= i_cfg.budget);

    // Execute the head beat
    always_comb begin
        n_match   = r_match;
        n_slot    = r_slot;
        n_words   = r_words;
        n_running = r_running;
        emit      = 1'b0;
        exh       = 1'b0;
        complete  = 1'b0;
        if (o_op_take) begin
            unique case (i_op.kind)
                kss_pkg::KIND_START: begin
                    n_match   = '0;
                    n_slot    = '0;
                    n_words   = '0;
                    n_running = (i_cfg.slot_cnt != '0) && (i_cfg.valid_limit != '0);
                end
                kss_pkg::KIND_WORD: begin
                    if (r_running) begin
                        if (stop_pre) begin
                            n_running = 1'b0;
                        end else begin
                            n_words = r_words + 1'b1;
                            if (i_op.hit) begin
                                n_match = r_match + 1'b1;
                                if (n_match >= {1'b0, r_cur}) begin
                                    emit   = 1'b1;
                                    n_slot = r_slot + 1'b1;
                                end
                            end
                            if (n_slot >= i_cfg.slot_cnt) begin
                                complete  = 1'b1;
                                n_running = 1'b0;
                            end else if (n_words >= i_cfg.budget) begin
                                exh       = 1'b1;
                                n_running = 1'b0;
                            end else if (n_match >= {1'b0, i_cfg.valid_limit}) begin
                                n_running = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res_in.slot      = r_slot[kss_pkg::IDX_W-1:0];
        res_in.chosen    = emit ? i_op.data : '0;
        res_in.complete  = complete;
        res_in.exhausted = exh;
        rq_push          = emit || exh;
        rd_addr          = n_slot[kss_pkg::IDX_W-1:0] + 1'b1;
    end

    // Update run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match   <= '0;
            r_slot    <= '0;
            r_words   <= '0;
            r_running <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_match   <= n_match;
            r_slot    <= n_slot;
            r_words   <= n_words;
            r_running <= n_running;
            r_fwd     <= is_load && (i_op.idx == rd_addr);
        end
    end

    // Track thresholds of the current slot and slot zero
    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_op.data;
        if (is_load && (i_op.idx == '0)) r_thr0 <= i_op.data;
        if (o_op_take) begin
            unique case (i_op.kind)
                kss_pkg::KIND_START: r_cur <= r_thr0;
                kss_pkg::KIND_WORD: begin
                    if (emit) r_cur <= next_thr;
                end
                kss_pkg::KIND_LOAD: begin
                    if (i_op.idx == r_slot[kss_pkg::IDX_W-1:0]) r_cur <= i_op.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Write the table and prefetch the next slot's threshold
    always_ff @(posedge i_clk) begin
        if (is_load) r_mem[i_op.idx] <= i_op.data;
        r_rd <= r_mem[rd_addr];
    end

    // Advance result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= 1'b0;
            r_rq_rp  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (rq_push) r_rq_wp <= !r_rq_wp;
            if (rq_pop)  r_rq_rp <= !r_rq_rp;
            if (rq_push && !rq_pop) r_rq_cnt <= r_rq_cnt + 1'b1;
            else if (rq_pop && !rq_push) r_rq_cnt <= r_rq_cnt - 1'b1;
        end
    end

    // Hold waiting results
    always_ff @(posedge i_clk) begin
        if (rq_push) r_rq[r_rq_wp] <= res_in;
    end

    assign o_res   = r_rq[r_rq_rp];
    assign o_empty = (r_rq_cnt == 2'd0);

    assign o_stat.running   = r_running;
    assign o_stat.slot      = r_slot;
    assign o_stat.match_cnt = r_match;
    assign o_stat.words     = r_words;

endmodule

### tb/subset_result_checker.sv
// Checker for the keystream subset sampler: tracks sampler state, predicts and compares results.
module subset_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [1:0]                 i_kind,
    input  logic [kss_pkg::IDX_W-1:0]  i_table_index,
    input  logic [kss_pkg::VAL_W-1:0]  i_table_value,
    input  logic [kss_pkg::VAL_W-1:0]  i_random_word,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [kss_pkg::IDX_W-1:0]  o_slot,
    input  logic [kss_pkg::VAL_W-1:0]  o_chosen_index,
    input  logic                       o_subset_complete,
    input  logic                       o_budget_exhausted,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic [31:0]                prdata,
    input  logic                       pready,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results,
    output int                         o_exhausted,
    output int                         o_beats
);

    logic [kss_pkg::VAL_W-1:0]  thresholds [kss_pkg::MAX_SLOTS];
    logic [kss_pkg::VAL_W-1:0]  limit_reg;
    logic [kss_pkg::SLOT_W-1:0] size_reg;
    logic [kss_pkg::CNT_W-1:0]  match_cnt;
    logic [kss_pkg::CNT_W-1:0]  words_used;
    logic [kss_pkg::SLOT_W-1:0] fill_pos;
    logic                       armed;
    kss_pkg::t_res              picks_due [$];

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_results   = 0;
        o_exhausted = 0;
        o_beats     = 0;
        limit_reg   = kss_pkg::RST_VALID_LIMIT;
        size_reg    = kss_pkg::RST_SLOT_TOTAL;
        match_cnt   = '0;
        words_used  = '0;
        fill_pos    = '0;
        armed       = 1'b0;
        foreach (thresholds[k]) thresholds[k] = '0;
    end

    // Number of bits needed to hold the limit; sets mask width and word budget
    function automatic int limit_bits(input logic [kss_pkg::VAL_W-1:0] v);
        int n;
        n = 0;
        while (v != '0) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    // Advance the sampler state by one accepted beat; queue the pick it causes
    task automatic sample_beat(input logic [1:0] kind,
                               input logic [kss_pkg::IDX_W-1:0] idx,
                               input logic [kss_pkg::VAL_W-1:0] tval,
                               input logic [kss_pkg::VAL_W-1:0] word);
        int                         nbits;
        logic [kss_pkg::CNT_W-1:0]  budget;
        logic [kss_pkg::VAL_W-1:0]  mask;
        logic [kss_pkg::VAL_W-1:0]  value;
        logic [kss_pkg::SLOT_W-1:0] slots;
        logic [kss_pkg::SLOT_W-1:0] taken_pos;
        logic                       taken;
        logic                       complete;
        logic                       exhausted;
        kss_pkg::t_res              pick;
        slots  = (size_reg > kss_pkg::SLOT_W'(kss_pkg::MAX_SLOTS))
               ? kss_pkg::SLOT_W'(kss_pkg::MAX_SLOTS) : size_reg;
        nbits  = limit_bits(limit_reg);
        budget = (kss_pkg::CNT_W'(1) << nbits) + kss_pkg::CNT_W'(kss_pkg::SLACK_WORDS);
        mask   = kss_pkg::VAL_W'((kss_pkg::CNT_W'(1) << nbits) - kss_pkg::CNT_W'(1));
        if (kind == kss_pkg::KIND_LOAD) begin
            thresholds[idx] = tval;
            o_beats++;
        end else if (kind == kss_pkg::KIND_START) begin
            match_cnt  = '0;
            fill_pos   = '0;
            words_used = '0;
            armed      = (slots != '0) && (limit_reg != '0);
            o_beats++;
        end else if (kind == kss_pkg::KIND_WORD && armed) begin
            // a stop condition that already holds ends the run; the word is dropped
            if (fill_pos >= slots || match_cnt >= kss_pkg::CNT_W'(limit_reg)
                || words_used >= budget) begin
                armed = 1'b0;
            end else begin
                o_beats++;
                words_used++;
                value     = word & mask;
                taken     = 1'b0;
                taken_pos = fill_pos;
                complete  = 1'b0;
                exhausted = 1'b0;
                if (value < limit_reg) begin
                    match_cnt++;
                    if (match_cnt >=
                        kss_pkg::CNT_W'(thresholds[fill_pos[kss_pkg::IDX_W-1:0]])) begin
                        taken = 1'b1;
                        fill_pos++;
                    end
                end
                if (fill_pos >= slots) begin
                    complete = 1'b1;
                    armed    = 1'b0;
                end else if (words_used >= budget) begin
                    exhausted = 1'b1;
                    armed     = 1'b0;
                end else if (match_cnt >= kss_pkg::CNT_W'(limit_reg)) begin
                    armed = 1'b0;
                end
                if (taken || exhausted) begin
                    pick.slot      = taken ? taken_pos[kss_pkg::IDX_W-1:0]
                                           : fill_pos[kss_pkg::IDX_W-1:0];
                    pick.chosen    = taken ? value : '0;
                    pick.complete  = complete;
                    pick.exhausted = exhausted;
                    picks_due.push_back(pick);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        kss_pkg::t_res want;
        if (!i_rst_n) begin
            limit_reg  = kss_pkg::RST_VALID_LIMIT;
            size_reg   = kss_pkg::RST_SLOT_TOTAL;
            match_cnt  = '0;
            words_used = '0;
            fill_pos   = '0;
            armed      = 1'b0;
            picks_due.delete();
        end else begin
            // compare the result beat with the oldest pick
            if (pop && !empty) begin
                if (picks_due.size() == 0) begin
                    $error("result beat with nothing expected: slot %0d, chosen_index %0d",
                           o_slot, o_chosen_index);
                    o_errors++;
                end else begin
                    want = picks_due.pop_front();
                    check_field("slot", 32'(want.slot), 32'(o_slot));
                    check_field("chosen_index", 32'(want.chosen), 32'(o_chosen_index));
                    check_field("subset_complete", 32'(want.complete), 32'(o_subset_complete));
                    check_field("budget_exhausted", 32'(want.exhausted),
                                32'(o_budget_exhausted));
                    o_results++;
                    if (want.exhausted) o_exhausted++;
                end
            end
            // predict from the input beat
            if (push && !full) begin
                sample_beat(i_kind, i_table_index, i_table_value, i_random_word);
            end
            // track register writes, check register reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == kss_pkg::REG_VALID_LIMIT) begin
                        limit_reg = pwdata[kss_pkg::VAL_W-1:0];
                    end else begin
                        size_reg = pwdata[kss_pkg::SLOT_W-1:0];
                    end
                end else if (paddr[2] == kss_pkg::REG_VALID_LIMIT) begin
                    check_field("prdata valid_limit", 32'(limit_reg), prdata);
                end else begin
                    check_field("prdata slot_total", 32'(size_reg), prdata);
                end
            end
        end
        o_pending = picks_due.size();
    end

endmodule

### tb/keystream_subset_sampler_test.sv
// Top of the keystream subset sampler testbench: clock, reset, stimulus and verdict.
module keystream_subset_sampler_test;

    localparam logic [1:0] KIND_SPARE       = 2'd3;
    localparam logic [2:0] ADDR_VALID_LIMIT = {kss_pkg::REG_VALID_LIMIT, 2'b00};
    localparam logic [2:0] ADDR_SLOT_TOTAL  = {kss_pkg::REG_SLOT_TOTAL, 2'b00};
    localparam int         IDLE_PCT         = 19;
    localparam int         RX_HOLD_CYCLES   = 150;
    localparam int         SETTLE_CYCLES    = 16;
    localparam int         RANDOM_BEATS     = 300;

    logic                       i_clk;
    logic                       i_rst_n        = 1'b0;
    logic                       push           = 1'b0;
    logic                       full;
    logic [1:0]                 i_kind         = '0;
    logic [kss_pkg::IDX_W-1:0]  i_table_index  = '0;
    logic [kss_pkg::VAL_W-1:0]  i_table_value  = '0;
    logic [kss_pkg::VAL_W-1:0]  i_random_word  = '0;
    logic                       empty;
    logic                       pop            = 1'b0;
    logic [kss_pkg::IDX_W-1:0]  o_slot;
    logic [kss_pkg::VAL_W-1:0]  o_chosen_index;
    logic                       o_subset_complete;
    logic                       o_budget_exhausted;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [2:0]                 paddr          = '0;
    logic [31:0]                pwdata         = '0;
    logic [31:0]                prdata;
    logic                       pready;

    int   chk_errors;
    int   chk_pending;
    int   chk_results;
    int   chk_exhausted;
    int   chk_beats;
    int   beats_snap = 0;
    logic calm       = 1'b0;
    logic hold_tog   = 1'b0;

    keystream_subset_sampler u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_kind             (i_kind),
        .i_table_index      (i_table_index),
        .i_table_value      (i_table_value),
        .i_random_word      (i_random_word),
        .empty              (empty),
        .pop                (pop),
        .o_slot             (o_slot),
        .o_chosen_index     (o_chosen_index),
        .o_subset_complete  (o_subset_complete),
        .o_budget_exhausted (o_budget_exhausted),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    subset_result_checker u_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_kind             (i_kind),
        .i_table_index      (i_table_index),
        .i_table_value      (i_table_value),
        .i_random_word      (i_random_word),
        .empty              (empty),
        .pop                (pop),
        .o_slot             (o_slot),
        .o_chosen_index     (o_chosen_index),
        .o_subset_complete  (o_subset_complete),
        .o_budget_exhausted (o_budget_exhausted),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_errors           (chk_errors),
        .o_pending          (chk_pending),
        .o_results          (chk_results),
        .o_exhausted        (chk_exhausted),
        .o_beats            (chk_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the run hangs
    initial begin
        #5000000;
        $display("Timeout: results or handshakes stopped arriving");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Snapshot the effective beat count away from the active edge
    always @(negedge i_clk) beats_snap <= chk_beats;

    // Result side: random pops, a long hold-off on request, always popping while calm outside a hold-off
    initial begin : result_drain
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one beat, with random idle cycles ahead of it unless calm; return at the accepting edge
    task automatic send_beat(input logic [1:0] kind, input logic [kss_pkg::IDX_W-1:0] idx,
                             input logic [kss_pkg::VAL_W-1:0] tval,
                             input logic [kss_pkg::VAL_W-1:0] word);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_kind        <= kind;
        i_table_index <= idx;
        i_table_value <= tval;
        i_random_word <= word;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_word(input logic [kss_pkg::VAL_W-1:0] word);
        send_beat(kss_pkg::KIND_WORD, kss_pkg::IDX_W'($urandom), kss_pkg::VAL_W'($urandom),
                  word);
    endtask

    task automatic send_start();
        send_beat(kss_pkg::KIND_START, kss_pkg::IDX_W'($urandom), kss_pkg::VAL_W'($urandom),
                  kss_pkg::VAL_W'($urandom));
    endtask

    task automatic put_threshold(input int idx, input int tval);
        send_beat(kss_pkg::KIND_LOAD, kss_pkg::IDX_W'(idx), kss_pkg::VAL_W'(tval),
                  kss_pkg::VAL_W'($urandom));
    endtask

    // Load nondecreasing thresholds into the first slots
    task automatic fill_table(input int n);
        int acc;
        acc = $urandom_range(2);
        for (int k = 0; k < n; k++) begin
            put_threshold(k, acc);
            acc += $urandom_range(3);
        end
    endtask

    // Hold the sender until every pick is out and the pipeline has emptied
    task automatic settle();
        push <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram both registers on an idle block and read them back
    task automatic set_regs(input logic [kss_pkg::VAL_W-1:0] lim,
                            input logic [kss_pkg::SLOT_W-1:0] size);
        settle();
        apb_cycle(1'b1, ADDR_VALID_LIMIT, 32'(lim));
        apb_cycle(1'b1, ADDR_SLOT_TOTAL, 32'(size));
        apb_cycle(1'b0, ADDR_VALID_LIMIT, '0);
        apb_cycle(1'b0, ADDR_SLOT_TOTAL, '0);
    endtask

    // Many picks in a row; the receiver holds off while words keep coming
    task automatic hold_off_burst();
        set_regs(16'hFFFF, 11'd40);
        fill_table(40);
        send_start();
        hold_tog <= ~hold_tog;
        for (int k = 0; k < 48; k++) send_word(kss_pkg::VAL_W'($urandom));
    endtask

    // Word budget runs out with no value on the last word, one pick before it
    task automatic exhaust_without_pick();
        logic [kss_pkg::VAL_W-1:0] word;
        set_regs(16'd2, 11'd4);
        for (int k = 0; k < 4; k++) put_threshold(k, k + 1);
        send_start();
        calm <= 1'b1;
        for (int k = 0; k < (1 << 2) + kss_pkg::SLACK_WORDS + 2; k++) begin
            word = kss_pkg::VAL_W'($urandom);
            word[1] = (k == 5) ? 1'b0 : 1'b1;
            send_word(word);
        end
        calm <= 1'b0;
    endtask

    // Word budget runs out on the very word that fills a slot
    task automatic exhaust_on_pick();
        logic [kss_pkg::VAL_W-1:0] word;
        set_regs(16'd1, 11'd2);
        put_threshold(0, $urandom_range(1));
        put_threshold(1, 1);
        send_start();
        for (int k = 0; k < (1 << 1) + kss_pkg::SLACK_WORDS + 1; k++) begin
            word = kss_pkg::VAL_W'($urandom);
            word[0] = (k == (1 << 1) + kss_pkg::SLACK_WORDS - 1) ? 1'b0 : 1'b1;
            send_word(word);
        end
    endtask

    // One random subset run, sometimes on freshly picked register settings
    task automatic random_run();
        logic [kss_pkg::VAL_W-1:0]  lim;
        logic [kss_pkg::SLOT_W-1:0] size;
        int                         slots;
        int                         n_words;
        int                         pick;
        if ($urandom_range(99) < 35) begin
            case ($urandom_range(7))
                0:       lim = 16'd1;
                1:       lim = 16'd2;
                2:       lim = kss_pkg::VAL_W'($urandom_range(3, 40));
                3:       lim = kss_pkg::VAL_W'($urandom_range(41, 1100));
                4:       lim = 16'hFFFF;
                5:       lim = 16'd0;
                default: lim = kss_pkg::VAL_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(9))
                0:       size = 11'd0;
                1:       size = 11'd1;
                7:       size = kss_pkg::SLOT_W'($urandom_range(17, 40));
                8:       size = kss_pkg::SLOT_W'(kss_pkg::MAX_SLOTS);
                9:       size = kss_pkg::SLOT_W'($urandom_range(kss_pkg::MAX_SLOTS + 1, 2047));
                default: size = kss_pkg::SLOT_W'($urandom_range(2, 16));
            endcase
            set_regs(lim, size);
        end
        size  = u_chk.size_reg;
        slots = (size > kss_pkg::MAX_SLOTS) ? kss_pkg::MAX_SLOTS : size;
        if ($urandom_range(99) < 30) put_threshold($urandom_range(1023), $urandom_range(65535));
        // load every slot that this run can reach
        fill_table((slots <= 40) ? slots : 64);
        // occasionally carry on with a short previous run instead of starting over
        if ($urandom_range(9) != 0 || u_chk.fill_pos >= 16) send_start();
        n_words = $urandom_range(1, 48);
        for (int k = 0; k < n_words; k++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_beat(KIND_SPARE, kss_pkg::IDX_W'($urandom), kss_pkg::VAL_W'($urandom),
                          kss_pkg::VAL_W'($urandom));
            end else if (pick < 7) begin
                send_start();
            end else begin
                send_word(kss_pkg::VAL_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int base;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of both registers
        apb_cycle(1'b0, ADDR_VALID_LIMIT, '0);
        apb_cycle(1'b0, ADDR_SLOT_TOTAL, '0);

        // thresholds zero and one, a repeated one, the largest value at the last index
        put_threshold(0, 0);
        put_threshold(1, 1);
        put_threshold(2, 1);
        put_threshold(kss_pkg::MAX_SLOTS - 1, 16'hFFFF);
        // unknown kind and a word while idle
        send_beat(KIND_SPARE, '1, '1, '1);
        send_word(16'hFFFF);
        // widest limit: all-ones word misses, then three picks fill the subset
        set_regs(16'hFFFF, 11'd3);
        send_start();
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h1234);
        send_word(16'hFFFE);
        send_word(16'h5555);
        // empty runs
        set_regs(16'd0, 11'd3);
        send_start();
        send_word(16'h0000);
        set_regs(16'd5, 11'd0);
        send_start();
        send_word(16'h0000);
        // match limit reached before the subset is full
        set_regs(16'd1, 11'd3);
        send_start();
        send_word(16'h0001);
        send_word(16'h0000);
        send_word(16'h0002);

        hold_off_burst();
        exhaust_without_pick();
        exhaust_on_pick();

        settle();
        base = beats_snap;
        while (beats_snap - base < RANDOM_BEATS) random_run();

        settle();
        $display("Run drove %0d effective input beats and checked %0d results, %0d of them",
                 chk_beats, chk_results, chk_exhausted);
        $display("on a spent word budget; limits 0 to 65535, slot totals 0 to 2047.");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
